>>> src/tcc_pkg.sv
package tcc_pkg;

   // Character cell geometry in pixels.
   localparam int unsigned GlyphW   = 8;
   localparam int unsigned GlyphH   = 16;
   localparam int unsigned CellGap  = 2;
   localparam int unsigned TabCells = 4;
   localparam int unsigned CellW    = GlyphW + CellGap;
   localparam int unsigned CellH    = GlyphH + CellGap;
   localparam int unsigned TabW     = CellW * TabCells;

   // Field widths.
   localparam int unsigned CoordW = 12;
   localparam int unsigned ByteW  = 8;

   // Configuration register indexes.
   localparam int unsigned CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] REG_SCREEN_WIDTH  = 1'd0;
   localparam logic [CsrIdxW-1:0] REG_SCREEN_HEIGHT = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [CoordW-1:0] SCREEN_WIDTH_RESET  = 12'd1024;
   localparam logic [CoordW-1:0] SCREEN_HEIGHT_RESET = 12'd768;

   // Control characters.
   localparam logic [ByteW-1:0] CHAR_TAB = 8'd9;
   localparam logic [ByteW-1:0] CHAR_LF  = 8'd10;
   localparam logic [ByteW-1:0] CHAR_CR  = 8'd13;

   // Command kinds.
   localparam logic KIND_DRAW   = 1'b0;
   localparam logic KIND_SCROLL = 1'b1;

   // One result beat.
   typedef struct packed {
      logic              kind;
      logic [CoordW-1:0] pos_x;
      logic [CoordW-1:0] pos_y;
      logic [ByteW-1:0]  glyph;
      logic [ByteW-1:0]  out_red;
      logic [ByteW-1:0]  out_green;
      logic [ByteW-1:0]  out_blue;
      logic              last;
   } rsp_type;

endpackage

>>> src/tcc_req_if.sv
interface tcc_req_if
   import tcc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] char_code;
   logic [ByteW-1:0] red;
   logic [ByteW-1:0] green;
   logic [ByteW-1:0] blue;

   modport source (output valid, output char_code, output red, output green, output blue,
                   input ready);
   modport sink   (input valid, input char_code, input red, input green, input blue,
                   output ready);
endinterface

>>> src/tcc_rsp_if.sv
interface tcc_rsp_if
   import tcc_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CoordW-1:0] pos_x;
   logic [CoordW-1:0] pos_y;
   logic [ByteW-1:0]  glyph;
   logic [ByteW-1:0]  out_red;
   logic [ByteW-1:0]  out_green;
   logic [ByteW-1:0]  out_blue;
   logic              last;

   modport source (output valid, output kind, output pos_x, output pos_y, output glyph,
                   output out_red, output out_green, output out_blue, output last,
                   input ready);
   modport sink   (input valid, input kind, input pos_x, input pos_y, input glyph,
                   input out_red, input out_green, input out_blue, input last,
                   output ready);
endinterface

>>> src/text_console_cursor.sv
// Pixel cursor for a framebuffer text console. Each request beat carries one
// character and its colour; a printable code gives a draw command at the
// cursor, then the cursor moves one 10-pixel cell. Tab moves to the next
// 40-pixel stop unless already on one, line feed wraps, carriage return is
// dropped. A wrap that would leave the screen gives a scroll command instead,
// so one character gives zero, one or two response beats, the last of them
// flagged. The cursor is updated in the cycle a character is taken, so a
// character can be taken every cycle; the results pass through a four-entry
// response queue, and request ready is held low while fewer than two entries
// are free. Characters with two response beats each are therefore held back
// by the single response port. The user must write the screen size through
// the csr_ port only while the block is idle; the block does not enforce it.
module text_console_cursor
   import tcc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   tcc_req_if.sink            req_bus,
   tcc_rsp_if.source          rsp_bus,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CoordW-1:0]  csr_wdata
);

   localparam int unsigned QDepth = 4;
   localparam int unsigned PtrW   = $clog2(QDepth);
   localparam int unsigned CntW   = $clog2(QDepth + 1);
   localparam int unsigned XW     = CoordW + 2;
   // ceil(2^16 / TabW); exact for every column the cursor can hold, which is
   // always a multiple of the 10-pixel cell.
   localparam int unsigned TabRecip = 1639;
   localparam int unsigned QW     = 7;

   logic [CoordW-1:0] screen_width_ff;
   logic [CoordW-1:0] screen_height_ff;
   logic [CoordW-1:0] cursor_x_ff, cursor_x_in;
   logic [CoordW-1:0] cursor_y_ff, cursor_y_in;

   rsp_type           queue_ff [QDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   logic              take;
   logic              pop;
   logic              is_cr, is_lf, is_tab, is_glyph;
   logic [22:0]       tab_prod;
   logic [QW-1:0]     tab_q;
   logic [XW-1:0]     stop_base;
   logic [XW-1:0]     x_adv;
   logic              wrap;
   logic [CoordW:0]   y_next;
   logic              scroll;
   logic [1:0]        push_n;
   rsp_type           draw_beat, scroll_beat, first_beat;

   // Handshakes: keep room for the two beats one character may cause.
   assign req_bus.ready = (count_ff <= CntW'(QDepth - 2));
   assign take          = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   // Character decode.
   assign is_cr    = (req_bus.char_code == CHAR_CR);
   assign is_lf    = (req_bus.char_code == CHAR_LF);
   assign is_tab   = (req_bus.char_code == CHAR_TAB);
   assign is_glyph = !(is_cr || is_lf || is_tab);

   // Tab stop: the quotient by the tab width comes from a reciprocal multiply.
   assign tab_prod  = 23'(cursor_x_ff) * 23'(TabRecip);
   assign tab_q     = tab_prod[22:16];
   assign stop_base = (XW'(tab_q) << 5) + (XW'(tab_q) << 3);

   // Horizontal advance, before the wrap check.
   always_comb begin
      if (is_tab) begin
         if (stop_base == XW'(cursor_x_ff)) begin
            x_adv = XW'(cursor_x_ff);
         end else begin
            x_adv = stop_base + XW'(TabW);
         end
      end else begin
         x_adv = XW'(cursor_x_ff) + XW'(CellW);
      end
   end

   // Wrap and scroll decisions; line feed always wraps.
   assign wrap   = is_lf || ((x_adv + XW'(CellW)) > XW'(screen_width_ff));
   assign y_next = (CoordW + 1)'(cursor_y_ff) + (CoordW + 1)'(CellH);
   assign scroll = wrap &&
                   ((y_next + (CoordW + 1)'(CellH)) > (CoordW + 1)'(screen_height_ff));

   // Next cursor position.
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (take && !is_cr) begin
         if (wrap) begin
            cursor_x_in = '0;
            if (!scroll) begin
               cursor_y_in = y_next[CoordW-1:0];
            end
         end else begin
            cursor_x_in = x_adv[CoordW-1:0];
         end
      end
   end

   // Result beats for the character just taken.
   always_comb begin
      draw_beat.kind      = KIND_DRAW;
      draw_beat.pos_x     = cursor_x_ff;
      draw_beat.pos_y     = cursor_y_ff;
      draw_beat.glyph     = req_bus.char_code;
      draw_beat.out_red   = req_bus.red;
      draw_beat.out_green = req_bus.green;
      draw_beat.out_blue  = req_bus.blue;
      draw_beat.last      = !scroll;

      scroll_beat           = '0;
      scroll_beat.kind      = KIND_SCROLL;
      scroll_beat.last      = 1'b1;

      first_beat = is_glyph ? draw_beat : scroll_beat;
   end

   always_comb begin
      if (!take || is_cr) begin
         push_n = 2'd0;
      end else begin
         push_n = 2'(is_glyph) + 2'(scroll);
      end
   end

   // Queue pointers and fill count.
   assign wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PtrW'(pop);
   assign count_in  = count_ff + CntW'(push_n) - CntW'(pop);

   // Response port reads the queue head.
   assign rsp_bus.valid     = (count_ff != '0);
   assign rsp_bus.kind      = queue_ff[rd_ptr_ff].kind;
   assign rsp_bus.pos_x     = queue_ff[rd_ptr_ff].pos_x;
   assign rsp_bus.pos_y     = queue_ff[rd_ptr_ff].pos_y;
   assign rsp_bus.glyph     = queue_ff[rd_ptr_ff].glyph;
   assign rsp_bus.out_red   = queue_ff[rd_ptr_ff].out_red;
   assign rsp_bus.out_green = queue_ff[rd_ptr_ff].out_green;
   assign rsp_bus.out_blue  = queue_ff[rd_ptr_ff].out_blue;
   assign rsp_bus.last      = queue_ff[rd_ptr_ff].last;

   // Queue storage: the first beat, and the scroll beat behind a draw.
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_beat;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrW'(1)] <= scroll_beat;
      end
   end

   // Control state, cursor and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
         cursor_x_ff      <= '0;
         cursor_y_ff      <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
               REG_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule
